>>> rtl/srg_pkg.sv
// Shared constants and helpers for the slant range geometry block.
// Field widths, register indexes, ellipsoid axes and output saturation.
// No dependencies.
package srg_pkg;

  localparam int POS_W   = 36;   // signed position component
  localparam int OUT_W   = 35;   // unsigned result fields
  localparam int CFG_W   = 31;   // Q30 look registers
  localparam int CFG_AW  = 1;    // register index width
  localparam int Q30_W   = 31;   // Q30 fraction including 1.0
  localparam int Q30_FRAC = 30;
  localparam int GUARD   = 15;   // guard fraction bits on radii
  localparam int LIMB_W  = 32;   // widest partial product operand

  localparam int POS_FRAC_BITS_DEF = 8;

  localparam logic [CFG_AW-1:0] REG_LOOK_SINE   = 1'b0;
  localparam logic [CFG_AW-1:0] REG_LOOK_COSINE = 1'b1;

  localparam logic [Q30_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Semi-axes in millimetres.
  localparam logic [63:0] SEMI_MAJOR_MM = 64'd6378137000;
  localparam logic [63:0] SEMI_MINOR_MM = 64'd6356752314;

  // Scale millimetres to position units, rounding to nearest.
  function automatic logic [63:0] scale_mm(logic [63:0] mm, int frac);
    return ((mm << frac) + 64'd500) / 64'd1000;
  endfunction

  // Magnitude of a two's complement component; the most negative code maps to 2^35.
  function automatic logic [POS_W-1:0] pos_mag(logic [POS_W-1:0] v);
    return v[POS_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Clamp a widened value to the output field range.
  function automatic logic [OUT_W-1:0] sat_out(logic [63:0] w);
    return (w > 64'(OUT_MAX)) ? OUT_MAX : w[OUT_W-1:0];
  endfunction

endpackage

>>> rtl/srg_mul.sv
// Two-stage multiplier built from limb partial products of at most 32x32 bits.
// Stage one registers the partial products, stage two registers their sum.
// No package dependencies.
module srg_mul #(
  parameter int AW = 36,
  parameter int BW = 36,
  parameter int LW = 18,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  input  logic [SW-1:0]   side_i,
  output logic            out_valid,
  output logic [AW+BW-1:0] prod,
  output logic [SW-1:0]   side_o
);

  localparam int NA   = (AW + LW - 1) / LW;
  localparam int NB   = (BW + LW - 1) / LW;
  localparam int SUMW = (NA + NB) * LW;

  logic [NA*LW-1:0] a_pad;
  logic [NB*LW-1:0] b_pad;
  logic [2*LW-1:0]  pp_r [NA][NB];
  logic [SW-1:0]    side1_r, side2_r;
  logic             v1_r, v2_r;
  logic [SUMW-1:0]  sum_nxt;
  logic [AW+BW-1:0] prod_r;

  assign a_pad = (NA*LW)'(a);
  assign b_pad = (NB*LW)'(b);

  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_r[i][j] <= (2*LW)'(a_pad[i*LW +: LW]) * (2*LW)'(b_pad[j*LW +: LW]);
      end
    end
    side1_r <= side_i;
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_nxt = sum_nxt + (SUMW'(pp_r[i][j]) << ((i + j) * LW));
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= sum_nxt[AW+BW-1:0];
    side2_r <= side1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign out_valid = v2_r;
  assign prod      = prod_r;
  assign side_o    = side2_r;

endmodule

>>> rtl/srg_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit in QW bits; the caller guarantees it. No package dependencies.
module srg_div #(
  parameter int NW = 102,
  parameter int DW = 72,
  parameter int QW = 31,
  parameter int SW = 1,
  localparam int CW = (NW > DW + QW) ? NW : DW + QW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] dvsr,
  input  logic [SW-1:0] side_i,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_o
);

  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] dvsr_r [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic          v_r    [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int I = QW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] dvsr_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic [CW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = num;
      assign dvsr_in = dvsr;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign dvsr_in = dvsr_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign side_in = side_r[k-1];
      assign v_in    = v_r[k-1];
    end

    assign trial = CW'(dvsr_in) << I;
    assign take  = CW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      rem_r[k]  <= take ? NW'(CW'(rem_in) - trial) : rem_in;
      quo_r[k]  <= take ? (quo_in | (QW'(1) << I)) : quo_in;
      dvsr_r[k] <= dvsr_in;
      side_r[k] <= side_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign quo       = quo_r[QW-1];
  assign side_o    = side_r[QW-1];

endmodule

>>> rtl/srg_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per register stage.
// Result is floor(sqrt(val)). No package dependencies.
module srg_sqrt #(
  parameter int VW = 102,
  parameter int SW = 1,
  localparam int RW = (VW + 1) / 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [VW-1:0] val,
  input  logic [SW-1:0] side_i,
  output logic          out_valid,
  output logic [RW-1:0] root,
  output logic [SW-1:0] side_o
);

  localparam int TW = VW + 2;

  logic [VW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [SW-1:0] side_r [RW];
  logic          v_r    [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [VW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic [TW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = val;
      assign root_in = '0;
      assign side_in = side_i;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
      assign v_in    = v_r[k-1];
    end

    // (root + 2^B)^2 - root^2; the two terms never overlap
    assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
    assign take  = TW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      rem_r[k]  <= take ? VW'(TW'(rem_in) - trial) : rem_in;
      root_r[k] <= take ? (root_in | (RW'(1) << B)) : root_in;
      side_r[k] <= side_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign root      = root_r[RW-1];
  assign side_o    = side_r[RW-1];

endmodule

>>> rtl/sar_slant_range_geometry.sv
// Throughput: one beat per cycle while busy is low; the pipeline of square root and
//   divider stages never stalls.
// Reset (rst_n low, synchronous) empties the pipeline, holds busy high until the first
//   clock edge with rst_n high, and returns look_sine to 0 and look_cosine to 1.0 in Q30.
module sar_slant_range_geometry
  import srg_pkg::*;
#(
  parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic                    cfg_we,
  input  logic [CFG_AW-1:0]       cfg_addr,
  input  logic [CFG_W-1:0]        cfg_wdata,
  output logic                    out_valid,
  output logic [OUT_W-1:0]        out_orbit_radius,
  output logic [OUT_W-1:0]        out_ellipsoid_radius,
  output logic [OUT_W-1:0]        out_near_slant_range,
  output logic                    out_no_view
);

  // ---------------------------------------------------------------------
  // Widths. Position magnitudes and their squares are fixed by the field
  // width; the ellipsoid terms grow with the fraction bits of the position.
  // ---------------------------------------------------------------------
  localparam int MAG_W  = POS_W;
  localparam int SQ_W   = 2 * MAG_W;            // x^2, also x^2+y^2+z^2 (< 2^72)
  localparam int HT_VW  = SQ_W + 2 * GUARD;     // |p|^2 with guard bits
  localparam int HT_W   = (HT_VW + 1) / 2;      // |p| with guard bits
  localparam int AX_W   = 23 + POS_FRAC_BITS;   // semi-axes in position units
  localparam int DAB_W  = 2 * AX_W;             // a^2 - b^2
  localparam int DEN_W  = 2 * AX_W + Q30_FRAC;  // b^2*cos2 + a^2*sin2
  localparam int Q_W    = (DEN_W + 1) / 2;
  localparam int NUM_W  = 2 * AX_W + Q30_FRAC;  // a*b in Q30
  localparam int ER_W   = AX_W + GUARD;         // ellipsoid radius with guard bits
  localparam int P_W    = HT_W + CFG_W - Q30_FRAC;
  localparam int DF_W   = (2 * ER_W > 2 * P_W) ? 2 * ER_W : 2 * P_W;
  localparam int SQR_W  = (DF_W + 1) / 2;
  localparam int SQ_LW  = (MAG_W + 1) / 2;
  localparam int ER_LW  = (ER_W + 1) / 2;
  localparam int P_LW   = (P_W + 1) / 2;
  localparam int MUL_LAT = 2;
  localparam int LAT = 6 + 3 * MUL_LAT + HT_W + Q30_W + Q_W + ER_W + SQR_W;

  // Ellipsoid constants, worked out at elaboration.
  localparam logic [63:0]  RA   = scale_mm(SEMI_MAJOR_MM, POS_FRAC_BITS);
  localparam logic [63:0]  RB   = scale_mm(SEMI_MINOR_MM, POS_FRAC_BITS);
  localparam logic [127:0] RA2  = 128'(RA) * 128'(RA);
  localparam logic [127:0] RB2  = 128'(RB) * 128'(RB);
  localparam logic [127:0] RAB  = 128'(RA) * 128'(RB);
  localparam logic [DAB_W-1:0] DAB    = DAB_W'(RA2 - RB2);
  localparam logic [DEN_W-1:0] RB2_SH = DEN_W'(RB2 << Q30_FRAC);
  localparam logic [NUM_W-1:0] NUMC   = NUM_W'(RAB << Q30_FRAC);

  // ---------------------------------------------------------------------
  // Handshake and configuration
  // ---------------------------------------------------------------------
  logic             busy_r;
  logic             in_acc;
  logic [CFG_W-1:0] look_sine_r, look_cosine_r;

  // Hold busy through reset and until the first edge with rst_n high; then a beat every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign in_acc = start & ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_sine_r   <= '0;
      look_cosine_r <= CFG_W'(ONE_Q30);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LOOK_SINE:   look_sine_r   <= cfg_wdata;
        REG_LOOK_COSINE: look_cosine_r <= cfg_wdata;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: register component magnitudes
  // ---------------------------------------------------------------------
  logic             v0_r;
  logic [MAG_W-1:0] mx_r, my_r, mz_r;

  always_ff @(posedge clk) begin
    mx_r <= pos_mag(in_pos_x);
    my_r <= pos_mag(in_pos_y);
    mz_r <= pos_mag(in_pos_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_acc;
    end
  end

  // ---------------------------------------------------------------------
  // Squares of the components (two stages)
  // ---------------------------------------------------------------------
  logic            sq_v;
  logic [SQ_W-1:0] x2, y2, z2;

  srg_mul #(.AW(MAG_W), .BW(MAG_W), .LW(SQ_LW), .SW(1)) u_sq_x (
    .clk, .rst_n, .in_valid(v0_r), .a(mx_r), .b(mx_r), .side_i(1'b0),
    .out_valid(sq_v), .prod(x2), .side_o()
  );
  srg_mul #(.AW(MAG_W), .BW(MAG_W), .LW(SQ_LW), .SW(1)) u_sq_y (
    .clk, .rst_n, .in_valid(v0_r), .a(my_r), .b(my_r), .side_i(1'b0),
    .out_valid(), .prod(y2), .side_o()
  );
  srg_mul #(.AW(MAG_W), .BW(MAG_W), .LW(SQ_LW), .SW(1)) u_sq_z (
    .clk, .rst_n, .in_valid(v0_r), .a(mz_r), .b(mz_r), .side_i(1'b0),
    .out_valid(), .prod(z2), .side_o()
  );

  // ---------------------------------------------------------------------
  // Stage 3: |p|^2; three squares of at most 2^70 each never carry out
  // ---------------------------------------------------------------------
  logic            v3_r;
  logic [SQ_W-1:0] r2_r, z2_r;

  always_ff @(posedge clk) begin
    r2_r <= x2 + y2 + z2;
    z2_r <= z2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= sq_v;
    end
  end

  // ---------------------------------------------------------------------
  // Orbit radius: sqrt(|p|^2) with guard bits; carry z^2 and |p|^2 along
  // ---------------------------------------------------------------------
  logic              ht_v;
  logic [HT_W-1:0]   ht_root;
  logic [2*SQ_W-1:0] ht_side;
  logic [SQ_W-1:0]   z2_a, r2_a;

  srg_sqrt #(.VW(HT_VW), .SW(2 * SQ_W)) u_orbit_sqrt (
    .clk, .rst_n, .in_valid(v3_r), .val({r2_r, {(2 * GUARD){1'b0}}}),
    .side_i({z2_r, r2_r}), .out_valid(ht_v), .root(ht_root), .side_o(ht_side)
  );

  assign {z2_a, r2_a} = ht_side;

  // ---------------------------------------------------------------------
  // Squared sine of latitude: z^2 * 2^30 / |p|^2. A position at the centre
  // gives a zero divisor; flag it and drop the quotient later.
  // ---------------------------------------------------------------------
  logic             s2_v;
  logic [Q30_W-1:0] s2_q;
  logic [HT_W:0]    s2_side;
  logic [HT_W-1:0]  htq_b;
  logic             centre_b;

  srg_div #(.NW(SQ_W + Q30_FRAC), .DW(SQ_W), .QW(Q30_W), .SW(HT_W + 1)) u_sin2_div (
    .clk, .rst_n, .in_valid(ht_v), .num({z2_a, {Q30_FRAC{1'b0}}}), .dvsr(r2_a),
    .side_i({ht_root, (r2_a == '0)}), .out_valid(s2_v), .quo(s2_q), .side_o(s2_side)
  );

  assign {htq_b, centre_b} = s2_side;

  // Stage C0: clamp sin^2 to 1.0, and force it to zero for a position at the centre
  logic             vc0_r;
  logic [Q30_W-1:0] s2_r;
  logic [HT_W-1:0]  htq_c0_r;

  always_ff @(posedge clk) begin
    priority if (centre_b) begin
      s2_r <= '0;
    end else if (s2_q > ONE_Q30) begin
      s2_r <= ONE_Q30;
    end else begin
      s2_r <= s2_q;
    end
    htq_c0_r <= htq_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc0_r <= 1'b0;
    end else begin
      vc0_r <= s2_v;
    end
  end

  // ---------------------------------------------------------------------
  // b^2*cos2 + a^2*sin2 is formed as b^2*2^30 + (a^2 - b^2)*sin2.
  // Alongside, |p|*sin and |p|*cos of the look angle.
  // ---------------------------------------------------------------------
  logic                   vc_m;
  logic [DAB_W+Q30_W-1:0] dab_s2;
  logic [HT_W-1:0]        htq_cm;
  logic [HT_W+CFG_W-1:0]  ps_prod, pc_prod;

  srg_mul #(.AW(DAB_W), .BW(Q30_W), .LW(LIMB_W), .SW(HT_W)) u_den_mul (
    .clk, .rst_n, .in_valid(vc0_r), .a(DAB), .b(s2_r), .side_i(htq_c0_r),
    .out_valid(vc_m), .prod(dab_s2), .side_o(htq_cm)
  );
  srg_mul #(.AW(HT_W), .BW(CFG_W), .LW(LIMB_W), .SW(1)) u_psin_mul (
    .clk, .rst_n, .in_valid(vc0_r), .a(htq_c0_r), .b(look_sine_r), .side_i(1'b0),
    .out_valid(), .prod(ps_prod), .side_o()
  );
  srg_mul #(.AW(HT_W), .BW(CFG_W), .LW(LIMB_W), .SW(1)) u_pcos_mul (
    .clk, .rst_n, .in_valid(vc0_r), .a(htq_c0_r), .b(look_cosine_r), .side_i(1'b0),
    .out_valid(), .prod(pc_prod), .side_o()
  );

  // Stage C1: the denominator does not exceed a^2 * 2^30
  logic             vc1_r;
  logic [DEN_W-1:0] den_r;
  logic [P_W-1:0]   p_r, hc_r;
  logic [HT_W-1:0]  htq_c1_r;

  always_ff @(posedge clk) begin
    den_r    <= DEN_W'((DAB_W + Q30_W)'(RB2_SH) + dab_s2);
    p_r      <= P_W'(ps_prod >> Q30_FRAC);
    hc_r     <= P_W'(pc_prod >> Q30_FRAC);
    htq_c1_r <= htq_cm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc1_r <= 1'b0;
    end else begin
      vc1_r <= vc_m;
    end
  end

  // ---------------------------------------------------------------------
  // Ellipsoid radius: a*b*2^30 / sqrt(den)
  // ---------------------------------------------------------------------
  localparam int PK_W = 2 * P_W + HT_W;

  logic            q_v;
  logic [Q_W-1:0]  q_root;
  logic [PK_W-1:0] q_side;

  srg_sqrt #(.VW(DEN_W), .SW(PK_W)) u_den_sqrt (
    .clk, .rst_n, .in_valid(vc1_r), .val(den_r), .side_i({p_r, hc_r, htq_c1_r}),
    .out_valid(q_v), .root(q_root), .side_o(q_side)
  );

  logic            er_v;
  logic [ER_W-1:0] erq;
  logic [PK_W-1:0] er_side;
  logic [P_W-1:0]  p_e, hc_e;
  logic [HT_W-1:0] htq_e;

  // Guard the divisor against zero, though the denominator never gets there.
  srg_div #(.NW(NUM_W), .DW(Q_W), .QW(ER_W), .SW(PK_W)) u_er_div (
    .clk, .rst_n, .in_valid(q_v), .num(NUMC),
    .dvsr((q_root == '0) ? Q_W'(1) : q_root),
    .side_i(q_side), .out_valid(er_v), .quo(erq), .side_o(er_side)
  );

  assign {p_e, hc_e, htq_e} = er_side;

  // ---------------------------------------------------------------------
  // Discriminant er^2 - (|p|*sin)^2
  // ---------------------------------------------------------------------
  localparam int FK_W = P_W + HT_W + ER_W;

  logic            e2_v;
  logic [2*ER_W-1:0] e2;
  logic [2*P_W-1:0]  p2;
  logic [FK_W-1:0] e2_side;
  logic [P_W-1:0]  hc_m;
  logic [HT_W-1:0] htq_m;
  logic [ER_W-1:0] erq_m;

  srg_mul #(.AW(ER_W), .BW(ER_W), .LW(ER_LW), .SW(FK_W)) u_e2_mul (
    .clk, .rst_n, .in_valid(er_v), .a(erq), .b(erq), .side_i({hc_e, htq_e, erq}),
    .out_valid(e2_v), .prod(e2), .side_o(e2_side)
  );
  srg_mul #(.AW(P_W), .BW(P_W), .LW(P_LW), .SW(1)) u_p2_mul (
    .clk, .rst_n, .in_valid(er_v), .a(p_e), .b(p_e), .side_i(1'b0),
    .out_valid(), .prod(p2), .side_o()
  );

  assign {hc_m, htq_m, erq_m} = e2_side;

  // Stage F: negative discriminant raises no view and feeds the root a zero
  logic            vf_r;
  logic [DF_W-1:0] e2_x, p2_x;
  logic            miss;
  logic [DF_W-1:0] diff_r;
  logic            nv_f_r;
  logic [P_W-1:0]  hc_f_r;
  logic [HT_W-1:0] htq_f_r;
  logic [ER_W-1:0] erq_f_r;

  assign e2_x = DF_W'(e2);
  assign p2_x = DF_W'(p2);
  assign miss = e2_x < p2_x;

  always_ff @(posedge clk) begin
    diff_r  <= miss ? '0 : (e2_x - p2_x);
    nv_f_r  <= miss;
    hc_f_r  <= hc_m;
    htq_f_r <= htq_m;
    erq_f_r <= erq_m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else begin
      vf_r <= e2_v;
    end
  end

  // ---------------------------------------------------------------------
  // sqrt of the discriminant
  // ---------------------------------------------------------------------
  localparam int GK_W = 1 + P_W + HT_W + ER_W;

  logic             sq_g_v;
  logic [SQR_W-1:0] sq_root;
  logic [GK_W-1:0]  g_side;
  logic             nv_g;
  logic [P_W-1:0]   hc_g;
  logic [HT_W-1:0]  htq_g;
  logic [ER_W-1:0]  erq_g;

  srg_sqrt #(.VW(DF_W), .SW(GK_W)) u_disc_sqrt (
    .clk, .rst_n, .in_valid(vf_r), .val(diff_r),
    .side_i({nv_f_r, hc_f_r, htq_f_r, erq_f_r}),
    .out_valid(sq_g_v), .root(sq_root), .side_o(g_side)
  );

  assign {nv_g, hc_g, htq_g, erq_g} = g_side;

  // ---------------------------------------------------------------------
  // Output stage: smaller root, drop guard bits, saturate
  // ---------------------------------------------------------------------
  logic [SQR_W-1:0] hc_x;
  logic [63:0]      rng_w;
  logic [OUT_W-1:0] range_nxt;
  logic             out_valid_r;
  logic [OUT_W-1:0] orbit_r, ell_r, range_r;
  logic             nv_r;

  assign hc_x  = SQR_W'(hc_g);
  assign rng_w = 64'(hc_x - sq_root) >> GUARD;

  always_comb begin
    priority if (nv_g) begin
      range_nxt = '0;
    end else if (hc_x >= sq_root) begin
      range_nxt = sat_out(rng_w);
    end else begin
      // satellite inside the ellipsoid: the smaller root is negative
      range_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    orbit_r <= sat_out(64'(htq_g) >> GUARD);
    ell_r   <= sat_out(64'(erq_g) >> GUARD);
    range_r <= range_nxt;
    nv_r    <= nv_g;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sq_g_v;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_orbit_radius     = orbit_r;
  assign out_ellipsoid_radius = ell_r;
  assign out_near_slant_range = range_r;
  assign out_no_view          = nv_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, LAT))
    else $error("result beat without an accepted beat at the fixed latency");

  a_no_view_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_view) |-> (out_near_slant_range == '0))
    else $error("no view beat carries a nonzero range");

  a_er_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (64'(out_ellipsoid_radius) <= RA))
    else $error("ellipsoid radius above the semi-major axis");

endmodule
